// ===== src/bitu_pkg.sv =====
// ----------------------------------------------------------------------------
// bitu_pkg
// Shared constants and types of the binary image thinning unit.
// ----------------------------------------------------------------------------
package bitu_pkg;

  localparam int MAX_WIDTH  = 512;
  localparam int MAX_HEIGHT = 512;
  localparam int DEPTH      = MAX_WIDTH * MAX_HEIGHT;
  localparam int AW         = $clog2(DEPTH);
  localparam int SW         = $clog2(DEPTH + 1);
  localparam int CW         = $clog2(MAX_WIDTH + 1);
  localparam int RW         = $clog2(MAX_HEIGHT + 1);

  localparam int B_LOW  = 2;
  localparam int B_HIGH = 6;
  localparam logic [7:0] FG_OUT = 8'd255;

  localparam logic [1:0] CFG_WIDTH  = 2'd0;
  localparam logic [1:0] CFG_HEIGHT = 2'd1;
  localparam logic [1:0] CFG_MAXIT  = 2'd2;

  localparam logic [9:0] WIDTH_RST  = 10'd512;
  localparam logic [9:0] HEIGHT_RST = 10'd512;
  localparam logic [7:0] MAXIT_RST  = 8'd200;

  typedef struct packed {
    logic [CW-1:0] w;
    logic [RW-1:0] h;
    logic [SW-1:0] size;
    logic [7:0]    limit;
  } bitu_dims_t;

  typedef struct packed {
    logic          re;
    logic [AW-1:0] raddr;
    logic          we;
    logic [AW-1:0] waddr;
  } bitu_fport_t;

endpackage

// ===== src/bitu_ram.sv =====
// ----------------------------------------------------------------------------
// bitu_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module bitu_ram #(
  parameter int DEPTH = 4,
  parameter int AW    = 2
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic          wdata,
  input  logic          re,
  input  logic [AW-1:0] raddr,
  output logic          rdata
);

  logic mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== src/bitu_thin.sv =====
// ----------------------------------------------------------------------------
// bitu_thin
// Thinning sequencer: marking scan over the frame store with a 3x3 window,
// then, when any pixel was marked, a deletion sweep driven from the mark store.
// ----------------------------------------------------------------------------
module bitu_thin (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  input  bitu_pkg::bitu_dims_t dims,
  input  logic                 fr_rdata,
  output bitu_pkg::bitu_fport_t fport,
  output logic                 busy,
  output logic [7:0]           iter
);
  import bitu_pkg::*;

  typedef enum logic [2:0] {E_IDLE, E_MARK, E_DEL, E_DRAIN, E_NEXT} state_t;

  state_t        state_r;
  logic [RW-1:0] r_r;
  logic [CW-1:0] fc_r;
  logic [1:0]    ph_r;
  logic [AW-1:0] base_r;
  logic [2:0]    prev_r, cur_r;
  logic [1:0]    colb_r;
  logic          inb_r;
  logic          anym_r, changed_r, sp_r;
  logic [7:0]    iter_r;
  logic [AW-1:0] cnt_r, da_r;
  logic          dv_r;

  logic [2:0]    newc;
  logic [7:0]    nb;
  logic [3:0]    bcnt;
  logic [3:0]    acnt;
  logic          ok, mark_bit, mark_we, mark_q;
  logic [AW-1:0] fc_ext, w_ext;
  logic          col_in, last_col, last_row, has_below;
  logic [8:0]    iter_inc;

  assign fc_ext    = AW'(fc_r);
  assign w_ext     = AW'(dims.w);
  assign col_in    = ({1'b0, fc_r} < {1'b0, dims.w});
  assign last_col  = (fc_r == dims.w);
  assign last_row  = (r_r == RW'(dims.h - 1'b1));
  assign has_below = !last_row;
  assign iter_inc  = {1'b0, iter_r} + 9'd1;

  // window: new column is [2]=below, [1]=row, [0]=above
  assign newc = {inb_r & fr_rdata, colb_r[1], colb_r[0]};
  // n2..n9 from msb down
  assign nb   = {cur_r[0], newc[0], newc[1], newc[2], cur_r[2], prev_r[2], prev_r[1],
                 prev_r[0]};
  assign bcnt = 4'($countones(nb));

  always_comb begin
    acnt = 4'd0;
    for (int i = 0; i < 8; i++) begin
      acnt = acnt + 4'(!nb[7 - i] && nb[(7 - i + 7) % 8]);
    end
  end

  // nb[7]=n2 nb[5]=n4 nb[3]=n6 nb[1]=n8
  always_comb begin
    if (!sp_r) begin
      ok = !(nb[7] && nb[5] && nb[3]) && !(nb[5] && nb[3] && nb[1]);
    end else begin
      ok = !(nb[7] && nb[5] && nb[1]) && !(nb[7] && nb[3] && nb[1]);
    end
  end

  assign mark_bit = cur_r[1] && (bcnt >= 4'(B_LOW)) && (bcnt <= 4'(B_HIGH)) &&
                    (acnt == 4'd1) && ok;
  assign mark_we  = (state_r == E_MARK) && (ph_r == 2'd3) && (fc_r != '0);

  bitu_ram #(.DEPTH(DEPTH), .AW(AW)) u_marks (
    .clk   (clk),
    .we    (mark_we),
    .waddr (base_r + fc_ext - AW'(1)),
    .wdata (mark_bit),
    .re    (state_r == E_DEL),
    .raddr (cnt_r),
    .rdata (mark_q)
  );

  always_comb begin
    fport.re    = (state_r == E_MARK) && (ph_r != 2'd3);
    case (ph_r)
      2'd0:    fport.raddr = base_r - w_ext + fc_ext;
      2'd1:    fport.raddr = base_r + fc_ext;
      default: fport.raddr = base_r + w_ext + fc_ext;
    endcase
    fport.we    = dv_r && mark_q && ((state_r == E_DEL) || (state_r == E_DRAIN));
    fport.waddr = da_r;
  end

  assign busy = (state_r != E_IDLE);
  assign iter = iter_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= E_IDLE;
      iter_r    <= '0;
      sp_r      <= 1'b0;
      changed_r <= 1'b0;
      anym_r    <= 1'b0;
      dv_r      <= 1'b0;
      ph_r      <= '0;
      fc_r      <= '0;
      r_r       <= '0;
      base_r    <= '0;
      cnt_r     <= '0;
    end else begin
      case (state_r)
        E_IDLE: begin
          if (start) begin
            iter_r    <= '0;
            sp_r      <= 1'b0;
            changed_r <= 1'b0;
            if (dims.limit != '0) begin
              state_r <= E_MARK;
              r_r     <= '0;
              fc_r    <= '0;
              ph_r    <= '0;
              base_r  <= '0;
              prev_r  <= '0;
              cur_r   <= '0;
              anym_r  <= 1'b0;
            end
          end
        end
        E_MARK: begin
          case (ph_r)
            2'd0:    inb_r <= (r_r != '0) && col_in;
            2'd1:    inb_r <= col_in;
            2'd2:    inb_r <= has_below && col_in;
            default: inb_r <= 1'b0;
          endcase
          if (ph_r == 2'd1) colb_r[0] <= inb_r & fr_rdata;
          if (ph_r == 2'd2) colb_r[1] <= inb_r & fr_rdata;
          if (ph_r == 2'd3) begin
            ph_r <= '0;
            if (mark_we && mark_bit) anym_r <= 1'b1;
            if (last_col) begin
              prev_r <= '0;
              cur_r  <= '0;
              fc_r   <= '0;
              if (last_row) begin
                changed_r <= changed_r | anym_r | (mark_we && mark_bit);
                if (anym_r || (mark_we && mark_bit)) begin
                  state_r <= E_DEL;
                  cnt_r   <= '0;
                end else begin
                  state_r <= E_NEXT;
                end
              end else begin
                r_r    <= r_r + 1'b1;
                base_r <= base_r + w_ext;
              end
            end else begin
              prev_r <= cur_r;
              cur_r  <= newc;
              fc_r   <= fc_r + 1'b1;
            end
          end else begin
            ph_r <= ph_r + 1'b1;
          end
        end
        E_DEL: begin
          dv_r  <= 1'b1;
          da_r  <= cnt_r;
          cnt_r <= cnt_r + 1'b1;
          if ({1'b0, cnt_r} == dims.size - 1'b1) state_r <= E_DRAIN;
        end
        E_DRAIN: begin
          dv_r    <= 1'b0;
          state_r <= E_NEXT;
        end
        E_NEXT: begin
          r_r    <= '0;
          fc_r   <= '0;
          ph_r   <= '0;
          base_r <= '0;
          prev_r <= '0;
          cur_r  <= '0;
          anym_r <= 1'b0;
          if (!sp_r) begin
            sp_r    <= 1'b1;
            state_r <= E_MARK;
          end else begin
            iter_r <= iter_inc[7:0];
            sp_r   <= 1'b0;
            if (!changed_r || (iter_inc >= {1'b0, dims.limit})) begin
              state_r <= E_IDLE;
            end else begin
              changed_r <= 1'b0;
              state_r   <= E_MARK;
            end
          end
        end
        default: state_r <= E_IDLE;
      endcase
    end
  end

endmodule

// ===== src/binary_image_thinning_unit.sv =====
// A read item's result is registered in the frame store, then in the output
// register; the channel takes no new item until it is taken, and load items
// one per cycle while no thinning or result is pending. After the last pixel
// of a frame loads, thinning runs as a burst: each subpass scans the frame with
// three frame-store reads per column, sweeps deletions if pixels were marked,
// then decides. Reset is synchronous, clears control state, not the frame store.
// ----------------------------------------------------------------------------
// binary_image_thinning_unit
// Frame-buffered Zhang-Suen thinning with load and read-out item streams.
// ----------------------------------------------------------------------------
module binary_image_thinning_unit (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic       in_mode,
  input  logic [7:0] in_pixel_value,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_pixel_out,
  output logic       out_last_out,
  output logic [7:0] out_iterations_used,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [1:0] cfg_index,
  input  logic [9:0] cfg_data
);
  import bitu_pkg::*;

  logic [9:0]       wcfg_r, hcfg_r;
  logic [7:0]       lim_r;
  bitu_dims_t       dims;
  logic [CW+RW-1:0] prod;
  logic [AW-1:0]    lp_r, rp_r, lp_eff, rp_eff;
  logic             rd_pend_r, rd_last_r, out_valid_r;
  logic             load_acc, read_acc, load_last, rd_last;
  logic             busy, start, fr_rdata;
  logic [7:0]       iter;
  bitu_fport_t      fport;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wcfg_r <= WIDTH_RST;
      hcfg_r <= HEIGHT_RST;
      lim_r  <= MAXIT_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_WIDTH:  wcfg_r <= cfg_data;
        CFG_HEIGHT: hcfg_r <= cfg_data;
        CFG_MAXIT:  lim_r  <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (wcfg_r == '0) dims.w = CW'(1);
    else if (int'(wcfg_r) > MAX_WIDTH) dims.w = CW'(MAX_WIDTH);
    else dims.w = CW'(wcfg_r);
    if (hcfg_r == '0) dims.h = RW'(1);
    else if (int'(hcfg_r) > MAX_HEIGHT) dims.h = RW'(MAX_HEIGHT);
    else dims.h = RW'(hcfg_r);
    prod       = (CW+RW)'(dims.w) * (CW+RW)'(dims.h);
    dims.size  = SW'(prod);
    dims.limit = lim_r;
  end

  assign in_stall = busy || rd_pend_r || out_valid_r;
  assign load_acc = in_valid && !in_stall && !in_mode;
  assign read_acc = in_valid && !in_stall && in_mode;

  // positions left beyond the frame by a size change restart at zero
  assign lp_eff    = ({1'b0, lp_r} >= dims.size) ? '0 : lp_r;
  assign rp_eff    = ({1'b0, rp_r} >= dims.size) ? '0 : rp_r;
  assign load_last = ({1'b0, lp_eff} + 1'b1 == dims.size);
  assign rd_last   = ({1'b0, rp_eff} == dims.size - 1'b1);
  assign start     = load_acc && load_last;

  bitu_thin u_thin (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .dims     (dims),
    .fr_rdata (fr_rdata),
    .fport    (fport),
    .busy     (busy),
    .iter     (iter)
  );

  bitu_ram #(.DEPTH(DEPTH), .AW(AW)) u_frame (
    .clk   (clk),
    .we    (busy ? fport.we : load_acc),
    .waddr (busy ? fport.waddr : lp_eff),
    .wdata (busy ? 1'b0 : (in_pixel_value != '0)),
    .re    (busy ? fport.re : read_acc),
    .raddr (busy ? fport.raddr : rp_eff),
    .rdata (fr_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lp_r        <= '0;
      rp_r        <= '0;
      rd_pend_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (load_acc) begin
        lp_r <= load_last ? '0 : lp_eff + 1'b1;
        if (load_last) rp_r <= '0;
      end
      if (read_acc) begin
        rp_r      <= rd_last ? '0 : rp_eff + 1'b1;
        rd_last_r <= rd_last;
      end
      rd_pend_r <= read_acc;
      if (rd_pend_r) begin
        out_valid_r         <= 1'b1;
        out_pixel_out       <= fr_rdata ? FG_OUT : 8'd0;
        out_last_out        <= rd_last_r;
        out_iterations_used <= iter;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid = out_valid_r;

endmodule

// ===== src/bitu_checker.sv =====
// ----------------------------------------------------------------------------
// bitu_checker
// Port-level checks of the thinning unit, bound to the top level.
// ----------------------------------------------------------------------------
module bitu_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_stall,
  input logic       in_mode,
  input logic       out_valid,
  input logic       out_stall,
  input logic [7:0] out_pixel_out,
  input logic       out_last_out
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_pixel_out)
                                && $stable(out_last_out))
    else $error("stalled result changed");

  a_pix_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_pixel_out == 8'd0) || (out_pixel_out == 8'd255))
    else $error("pixel out not binary");

  a_read_lat: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && in_mode |-> ##2 out_valid)
    else $error("read item gave no result");

  a_stall_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> in_stall)
    else $error("item accepted while result pending");

  a_rst: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind binary_image_thinning_unit bitu_checker u_bitu_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_valid      (in_valid),
  .in_stall      (in_stall),
  .in_mode       (in_mode),
  .out_valid     (out_valid),
  .out_stall     (out_stall),
  .out_pixel_out (out_pixel_out),
  .out_last_out  (out_last_out)
);

// ===== tb/sv/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the binary image thinning unit: loads frames of many
// sizes, predicts the thinned frame in place and checks every read-out item.
// ----------------------------------------------------------------------------
module tb;
  import bitu_pkg::*;

  localparam logic MODE_LOAD = 1'b0;
  localparam logic MODE_READ = 1'b1;
  localparam int   WD_LIMIT  = 3000000;
  localparam int   HOLD_LEN  = 400;

  typedef struct {
    logic       mode;
    logic [7:0] value;
  } pix_item_t;

  typedef struct {
    logic [7:0] pixel;
    logic       last;
    logic [7:0] iters;
  } thin_pix_t;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic       in_mode = 1'b0;
  logic [7:0] in_pixel_value = 8'd0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic [7:0] out_pixel_out;
  logic       out_last_out;
  logic [7:0] out_iterations_used;
  logic       cfg_valid = 1'b0;
  logic       cfg_ready;
  logic [1:0] cfg_index = 2'd0;
  logic [9:0] cfg_data = 10'd0;

  // predictor state
  bit         img [DEPTH];
  bit         del_mark [DEPTH];
  int         ld_pos, rd_pos, it_cnt;
  logic [9:0] reg_w, reg_h;
  logic [7:0] reg_maxit;

  pix_item_t  pend_items[$];
  thin_pix_t  exp_pixels[$];
  int         errors, n_items, n_reads, n_frames, n_phases, idle_cycles, gap_left, burst_left;
  int         hold_cnt;
  bit         hold_req, hold_done;

  always #6 clk = ~clk;

  binary_image_thinning_unit i_dut (.*);

  function automatic int eff_w();
    int w;
    w = reg_w;
    if (w < 1) w = 1;
    if (w > MAX_WIDTH) w = MAX_WIDTH;
    return w;
  endfunction

  function automatic int eff_h();
    int h;
    h = reg_h;
    if (h < 1) h = 1;
    if (h > MAX_HEIGHT) h = MAX_HEIGHT;
    return h;
  endfunction

  function automatic bit nb(int r, int c, int w, int h);
    if (r < 0 || c < 0 || r >= h || c >= w) return 1'b0;
    return img[r*w + c];
  endfunction

  function automatic int mark_subpass(int w, int h, bit sp);
    int cnt, idx, b, a;
    bit n2, n3, n4, n5, n6, n7, n8, n9, ok;
    cnt = 0;
    for (int r = 0; r < h; r++) begin
      for (int c = 0; c < w; c++) begin
        idx = r*w + c;
        del_mark[idx] = 1'b0;
        if (img[idx]) begin
          n2 = nb(r-1, c, w, h);   n3 = nb(r-1, c+1, w, h);
          n4 = nb(r, c+1, w, h);   n5 = nb(r+1, c+1, w, h);
          n6 = nb(r+1, c, w, h);   n7 = nb(r+1, c-1, w, h);
          n8 = nb(r, c-1, w, h);   n9 = nb(r-1, c-1, w, h);
          b = n2 + n3 + n4 + n5 + n6 + n7 + n8 + n9;
          a = (!n2 && n3) + (!n3 && n4) + (!n4 && n5) + (!n5 && n6) +
              (!n6 && n7) + (!n7 && n8) + (!n8 && n9) + (!n9 && n2);
          if (!sp) ok = !(n2 && n4 && n6) && !(n4 && n6 && n8);
          else     ok = !(n2 && n4 && n8) && !(n2 && n6 && n8);
          if (b >= B_LOW && b <= B_HIGH && a == 1 && ok) begin
            del_mark[idx] = 1'b1;
            cnt++;
          end
        end
      end
    end
    return cnt;
  endfunction

  task automatic thin_frame(int w, int h);
    bit chg;
    it_cnt = 0;
    while (it_cnt < reg_maxit) begin
      chg = 1'b0;
      for (int sp = 0; sp < 2; sp++) begin
        if (mark_subpass(w, h, sp[0]) > 0) begin
          for (int i = 0; i < w*h; i++) if (del_mark[i]) img[i] = 1'b0;
          chg = 1'b1;
        end
      end
      it_cnt++;
      if (!chg) break;
    end
  endtask

  task automatic predict_item(logic mode, logic [7:0] value);
    int w, h, size;
    thin_pix_t t;
    w = eff_w();
    h = eff_h();
    size = w*h;
    if (mode == MODE_LOAD) begin
      if (ld_pos >= size) ld_pos = 0;
      img[ld_pos] = (value != 8'd0);
      ld_pos++;
      if (ld_pos == size) begin
        thin_frame(w, h);
        ld_pos = 0;
        rd_pos = 0;
        n_frames++;
      end
    end else begin
      if (rd_pos >= size) rd_pos = 0;
      t.pixel = img[rd_pos] ? FG_OUT : 8'd0;
      t.last  = (rd_pos == size - 1);
      t.iters = it_cnt[7:0];
      exp_pixels.push_back(t);
      rd_pos++;
      if (rd_pos == size) rd_pos = 0;
    end
  endtask

  task automatic report(string what, int got, int want);
    $display("mismatch %s: got %0d expected %0d", what, got, want);
    errors++;
  endtask

  // item driver: bursts of random length, random gaps between them
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      gap_left <= 0;
      burst_left <= 0;
    end else begin
      if (in_valid && !in_stall) void'(pend_items.pop_front());
      if (!in_valid || !in_stall) begin
        if (gap_left > 0) begin
          gap_left <= gap_left - 1;
          in_valid <= 1'b0;
        end else if (pend_items.size() > 0) begin
          in_valid <= 1'b1;
          in_mode <= pend_items[0].mode;
          in_pixel_value <= pend_items[0].value;
          if (burst_left == 0) begin
            burst_left <= $urandom_range(1, 40);
            gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
          end else begin
            burst_left <= burst_left - 1;
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // receiver stall pattern, with one long hold-off on request
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
      hold_cnt <= 0;
      hold_done <= 1'b0;
    end else if (hold_req && !hold_done) begin
      out_stall <= 1'b1;
      hold_cnt <= hold_cnt + 1;
      if (hold_cnt == HOLD_LEN) begin
        hold_done <= 1'b1;
        out_stall <= 1'b0;
      end
    end else begin
      case ((n_phases >> 1) % 3)
        0: out_stall <= 1'b0;
        1: out_stall <= ($urandom_range(0, 3) == 0);
        default: out_stall <= ($urandom_range(0, 1) == 0);
      endcase
    end
  end

  // monitor: prediction, checking and watchdog
  always @(posedge clk) begin
    thin_pix_t t;
    bit moved;
    if (rst_n) begin
      moved = 1'b0;
      if (cfg_valid && cfg_ready) begin
        moved = 1'b1;
        case (cfg_index)
          CFG_WIDTH:  reg_w = cfg_data;
          CFG_HEIGHT: reg_h = cfg_data;
          CFG_MAXIT:  reg_maxit = cfg_data[7:0];
          default: ;
        endcase
      end
      if (in_valid && !in_stall) begin
        moved = 1'b1;
        n_items++;
        predict_item(in_mode, in_pixel_value);
      end
      if (out_valid && !out_stall) begin
        moved = 1'b1;
        n_reads++;
        if (exp_pixels.size() == 0) begin
          report("unexpected item pixel_out", out_pixel_out, -1);
        end else begin
          t = exp_pixels.pop_front();
          if (out_pixel_out !== t.pixel) report("pixel_out", out_pixel_out, t.pixel);
          if (out_last_out !== t.last) report("last_out", out_last_out, t.last);
          if (out_iterations_used !== t.iters)
            report("iterations_used", out_iterations_used, t.iters);
        end
      end
      idle_cycles <= moved ? 0 : idle_cycles + 1;
      if (idle_cycles >= WD_LIMIT) begin
        $display("timeout: no progress in %0d cycles", WD_LIMIT);
        $display("Test completed with failures");
        $finish;
      end
    end
  end

  task automatic cfg_write(logic [1:0] idx, logic [9:0] data);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  task automatic wait_idle();
    while (pend_items.size() > 0 || exp_pixels.size() > 0 || in_valid) @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  task automatic set_dims(int w, int h, int maxit);
    wait_idle();
    cfg_write(CFG_WIDTH, w[9:0]);
    cfg_write(CFG_HEIGHT, h[9:0]);
    cfg_write(CFG_MAXIT, maxit[9:0]);
    n_phases++;
  endtask

  task automatic push(logic mode, logic [7:0] value);
    pix_item_t p;
    p.mode = mode;
    p.value = value;
    pend_items.push_back(p);
  endtask

  function automatic logic [7:0] fg_value(bit on);
    return on ? 8'($urandom_range(1, 255)) : 8'd0;
  endfunction

  // a full frame of thick blobs or noise, preceded by what finishes a partial frame
  task automatic push_frame(int size, int w);
    int nblob, r0, c0, bh, bw, r, c, lead;
    bit noisy;
    noisy = ($urandom_range(0, 3) == 0);
    lead = (ld_pos >= size || ld_pos == 0) ? 0 : size - ld_pos;
    for (int i = 0; i < lead; i++) push(MODE_LOAD, fg_value($urandom_range(0, 1)));
    nblob = $urandom_range(1, 4);
    for (int i = 0; i < size; i++) begin
      r = i / w;
      c = i % w;
      if (noisy) begin
        push(MODE_LOAD, fg_value($urandom_range(0, 2) != 0));
      end else begin
        // blob membership from a hash of position keeps shapes thick
        r0 = (r / 3) * 7 + (c / 3) * 13 + nblob;
        push(MODE_LOAD, fg_value((r0 % 5) != 0));
      end
    end
  endtask

  task automatic run_phase(int w, int h, int maxit);
    int size, n, pick;
    set_dims(w, h, maxit);
    size = eff_w() * eff_h();
    push_frame(size, eff_w());
    // large frames get a short tail of mostly reads to keep the item count near the goal
    n = (size > 64) ? $urandom_range(32, 64) : $urandom_range(size, 2*size + 4);
    for (int i = 0; i < n; i++) begin
      pick = $urandom_range(0, 9);
      if (pick < 7) push(MODE_READ, 8'($urandom));
      else push(MODE_LOAD, fg_value($urandom_range(0, 1)));
    end
    for (int i = 0; i < 3; i++) push(MODE_READ, 8'($urandom));
  endtask

  initial begin
    logic [7:0] dvals [8] = '{8'd0, 8'd255, 8'd1, 8'd128, 8'd85, 8'd170, 8'd0, 8'd2};
    int w, h, m;
    ld_pos = 0; rd_pos = 0; it_cnt = 0;
    reg_w = WIDTH_RST; reg_h = HEIGHT_RST; reg_maxit = MAXIT_RST;
    errors = 0; n_items = 0; n_reads = 0; n_frames = 0; n_phases = 0; idle_cycles = 0;
    hold_req = 1'b0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // directed: field extremes on a small frame, then read-out
    set_dims(5, 4, 255);
    for (int i = 0; i < 20; i++) push(MODE_LOAD, dvals[i % 8]);
    for (int i = 0; i < 5; i++) push(MODE_READ, (i % 2) ? 8'hFF : 8'h00);

    // out-of-range and extreme sizes, zero iteration limit
    run_phase(0, 3, 1);
    run_phase(1023, 1, 3);
    run_phase(7, 6, 0);
    run_phase(1, 1023, 2);

    // receiver holds off while reads keep coming, once thinning is over
    set_dims(6, 6, 200);
    push_frame(36, 6);
    while (pend_items.size() > 0 || in_valid) @(posedge clk);
    @(posedge clk);
    while (in_stall) @(posedge clk);
    hold_req = 1'b1;
    for (int i = 0; i < 60; i++) push(MODE_READ, 8'($urandom));

    while (n_items + pend_items.size() < 2000) begin
      w = $urandom_range(3, 16);
      h = $urandom_range(3, 16);
      case ($urandom_range(0, 3))
        0: m = 1;
        1: m = 255;
        2: m = $urandom_range(2, 4);
        default: m = $urandom_range(1, 255);
      endcase
      run_phase(w, h, m);
    end
    wait_idle();
    repeat (20) @(posedge clk);

    $display("covered %0d items, %0d frames thinned, %0d pixels read over %0d settings",
             n_items, n_frames, n_reads, n_phases);
    if (errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("%0d mismatches", errors);
      $display("Test completed with failures");
    end
    $finish;
  end
endmodule
